// File: design/assert_macros.svh
// Assertion macros shared by the joystick axis conditioner RTL.
// Standalone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define JAC_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Implication form: antecedent holds, consequent must hold in the following cycle.
`define JAC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/jac_pkg.sv
// Shared constants, types and register codes of the joystick axis conditioner.
// No dependencies.
package jac_pkg;

  localparam int unsigned WINDOW_LENGTH = 5;
  localparam int unsigned AXIS_COUNT    = 2;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned CENTER_W   = 12;
  localparam int unsigned DEAD_W     = 9;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned CFG_IDX_W  = 1;

  // Window sum and index widths
  localparam int unsigned SUM_MAX = WINDOW_LENGTH * ((1 << SAMPLE_W) - 1);
  localparam int unsigned SUM_W   = $clog2(SUM_MAX + 1);
  localparam int unsigned POS_W   = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int unsigned AX_W    = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

  // Floor division by the window length as a reciprocal multiply.
  // The extra four shift bits cover window lengths up to 16 exactly.
  localparam int unsigned DIV_SHIFT = SUM_W + 4;
  localparam int unsigned RECIP     = ((1 << DIV_SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
  localparam int unsigned RECIP_W   = DIV_SHIFT + 1;
  localparam int unsigned PROD_W    = SUM_W + RECIP_W;

  // Scaling: divide by 8 toward zero
  localparam int unsigned SCALE_SHIFT = 3;
  localparam int unsigned SCALE_ROUND = (1 << SCALE_SHIFT) - 1;
  localparam int unsigned SCALED_W    = SAMPLE_W + 1 - SCALE_SHIFT;

  localparam logic [CENTER_W-1:0] CENTER_RESET = CENTER_W'(2048);
  localparam logic [DEAD_W-1:0]   DEAD_RESET   = DEAD_W'(80);
  localparam logic [BYTE_W-1:0]   END_MARK     = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER = 1'b0,
    REG_DEAD   = 1'b1
  } cfg_reg_e;

  // Beat from the window stage to the scaling stage
  typedef struct packed {
    logic             axis;
    logic [SUM_W-1:0] sum;
  } sum_beat_t;

  // Beat from the scaling stage to the packet serializer
  typedef struct packed {
    logic               axis;
    logic [VALUE_W-1:0] value;
  } pkt_beat_t;

endpackage

// File: design/jac_window.sv
// Per-axis circular sample window and running sum, with the first stage register.
// Depends on jac_pkg.
module jac_window
  import jac_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                axis_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic                sum_valid_o,
  input  logic                sum_ready_i,
  output sum_beat_t           sum_beat_o
);

  logic [SAMPLE_W-1:0] win_q [AXIS_COUNT][WINDOW_LENGTH];
  logic [POS_W-1:0]    pos_q [AXIS_COUNT];
  logic [SUM_W-1:0]    sum_q [AXIS_COUNT];
  logic                sum_valid_q, sum_valid_d;
  sum_beat_t           sum_beat_q;

  logic                accept, ax_ok, store;
  logic [AX_W-1:0]     ax_idx;
  logic [POS_W-1:0]    pos_cur, pos_nxt;
  logic [SAMPLE_W-1:0] oldest;
  logic [SUM_W-1:0]    new_sum;

  assign in_ready_o = !sum_valid_q || sum_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign ax_ok      = (32'(axis_i) < AXIS_COUNT);
  assign store      = accept && ax_ok;
  assign ax_idx     = AX_W'(axis_i);

  // Oldest entry, new sum and next write position
  always_comb begin
    pos_cur = pos_q[ax_idx];
    if (32'(pos_cur) >= WINDOW_LENGTH) begin
      pos_cur = '0;
    end
    oldest  = win_q[ax_idx][pos_cur];
    new_sum = SUM_W'(sum_q[ax_idx] - SUM_W'(oldest) + SUM_W'(sample_i));
    if (32'(pos_cur) == WINDOW_LENGTH - 1) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = POS_W'(pos_cur + 1'b1);
    end
  end

  // Stage valid: set on a stored beat, cleared when taken
  always_comb begin
    sum_valid_d = sum_valid_q;
    if (store) begin
      sum_valid_d = 1'b1;
    end else if (sum_ready_i) begin
      sum_valid_d = 1'b0;
    end
  end

  // Window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AXIS_COUNT; a++) begin
        pos_q[a] <= '0;
        sum_q[a] <= '0;
        for (int e = 0; e < WINDOW_LENGTH; e++) begin
          win_q[a][e] <= '0;
        end
      end
      sum_valid_q <= 1'b0;
    end else begin
      sum_valid_q <= sum_valid_d;
      if (store) begin
        win_q[ax_idx][pos_cur] <= sample_i;
        pos_q[ax_idx]          <= pos_nxt;
        sum_q[ax_idx]          <= new_sum;
      end
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk_i) begin
    if (store) begin
      sum_beat_q.axis <= axis_i;
      sum_beat_q.sum  <= new_sum;
    end
  end

  assign sum_valid_o = sum_valid_q;
  assign sum_beat_o  = sum_beat_q;

endmodule

// File: design/jac_scale.sv
// Average, centering, scaling and dead zone, with the packet value register.
// Depends on jac_pkg.
module jac_scale
  import jac_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                sum_valid_i,
  output logic                sum_ready_o,
  input  sum_beat_t           sum_beat_i,
  input  logic [CENTER_W-1:0] center_i,
  input  logic [DEAD_W-1:0]   dead_i,
  output logic                pkt_valid_o,
  input  logic                pkt_ready_i,
  output pkt_beat_t           pkt_beat_o
);

  logic                      pkt_valid_q, pkt_valid_d;
  pkt_beat_t                 pkt_beat_q;
  logic                      take;
  logic [PROD_W-1:0]         prod;
  logic [SAMPLE_W-1:0]       avg;
  logic signed [SAMPLE_W:0]  diff, adj;
  logic signed [SCALED_W-1:0] scaled;
  logic signed [SCALED_W:0]  q_x, dz_x;
  logic                      in_zone;
  logic [VALUE_W-1:0]        value;

  assign sum_ready_o = !pkt_valid_q || pkt_ready_i;
  assign take        = sum_valid_i && sum_ready_o;

  // Floor divide by the window length
  assign prod = PROD_W'(sum_beat_i.sum) * PROD_W'(RECIP);
  assign avg  = prod[DIV_SHIFT +: SAMPLE_W];

  // Center, divide by 8 toward zero, apply the dead zone
  always_comb begin
    diff = $signed({1'b0, avg}) - $signed({1'b0, center_i});
    if (diff[SAMPLE_W]) begin
      adj = diff + $signed((SAMPLE_W + 1)'(SCALE_ROUND));
    end else begin
      adj = diff;
    end
    scaled  = adj[SAMPLE_W:SCALE_SHIFT];
    q_x     = {scaled[SCALED_W-1], scaled};
    dz_x    = $signed((SCALED_W + 1)'(dead_i));
    in_zone = (q_x < dz_x) && (q_x > -dz_x);
    if (in_zone) begin
      value = '0;
    end else begin
      value = {{(VALUE_W - SCALED_W){scaled[SCALED_W-1]}}, scaled};
    end
  end

  always_comb begin
    pkt_valid_d = pkt_valid_q;
    if (take) begin
      pkt_valid_d = 1'b1;
    end else if (pkt_ready_i) begin
      pkt_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_valid_q <= 1'b0;
    end else begin
      pkt_valid_q <= pkt_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      pkt_beat_q.axis  <= sum_beat_i.axis;
      pkt_beat_q.value <= value;
    end
  end

  assign pkt_valid_o = pkt_valid_q;
  assign pkt_beat_o  = pkt_beat_q;

endmodule

// File: design/jac_serializer.sv
// Four-byte packet serializer: axis, low byte, high byte, end mark.
// Depends on jac_pkg.
module jac_serializer
  import jac_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pkt_valid_i,
  output logic              pkt_ready_o,
  input  pkt_beat_t         pkt_beat_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] packet_byte_o,
  output logic              last_byte_o
);

  typedef enum logic [1:0] {
    BYTE_AXIS = 2'd0,
    BYTE_LOW  = 2'd1,
    BYTE_HIGH = 2'd2,
    BYTE_END  = 2'd3
  } byte_sel_e;

  logic      ser_valid_q, ser_valid_d;
  byte_sel_e sel_q, sel_d;
  pkt_beat_t ser_beat_q;
  logic      load, beat_out;

  assign beat_out    = ser_valid_q && out_ready_i;
  assign load        = !ser_valid_q || (beat_out && (sel_q == BYTE_END));
  assign pkt_ready_o = load;

  // Byte pointer and holding valid
  always_comb begin
    ser_valid_d = ser_valid_q;
    sel_d       = sel_q;
    if (load) begin
      ser_valid_d = pkt_valid_i;
      sel_d       = BYTE_AXIS;
    end else if (beat_out) begin
      unique case (sel_q)
        BYTE_AXIS: sel_d = BYTE_LOW;
        BYTE_LOW:  sel_d = BYTE_HIGH;
        BYTE_HIGH: sel_d = BYTE_END;
        default:   sel_d = BYTE_AXIS;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_valid_q <= 1'b0;
      sel_q       <= BYTE_AXIS;
    end else begin
      ser_valid_q <= ser_valid_d;
      sel_q       <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && pkt_valid_i) begin
      ser_beat_q <= pkt_beat_i;
    end
  end

  // Output byte select
  always_comb begin
    unique case (sel_q)
      BYTE_AXIS: packet_byte_o = BYTE_W'(ser_beat_q.axis);
      BYTE_LOW:  packet_byte_o = ser_beat_q.value[BYTE_W-1:0];
      BYTE_HIGH: packet_byte_o = ser_beat_q.value[2*BYTE_W-1:BYTE_W];
      default:   packet_byte_o = END_MARK;
    endcase
  end

  assign out_valid_o = ser_valid_q;
  assign last_byte_o = (sel_q == BYTE_END);

endmodule

// File: design/joystick_axis_conditioner_top.sv
// Top level of the joystick axis conditioner: config registers and the stage chain.
// Depends on jac_pkg, jac_window, jac_scale, jac_serializer and assert_macros.svh.
//
//   channel   direction  handshake                 payload
//   input     in         in_valid_i / in_ready_o   axis_i, sample_i
//   output    out        out_valid_o / out_ready_i packet_byte_o, last_byte_o
//   config    in         cfg_we_i                  cfg_index_i, cfg_data_i
//
// Each sample yields four output beats, one per cycle while out_ready_i is high, so the
// sustained sample rate is set by the single-byte output port.
// An input beat is registered in the window, scale and serializer stages in turn before its first output beat.
// Reset clears the windows, running sums and write positions at once; no clearing pass.
// Output stalls back up through the serializer, scale and window stages in turn.
`include "assert_macros.svh"

module joystick_axis_conditioner_top
  import jac_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  axis_i,
  input  logic [SAMPLE_W-1:0]   sample_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [BYTE_W-1:0]     packet_byte_o,
  output logic                  last_byte_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [CENTER_W-1:0] center_q;
  logic [DEAD_W-1:0]   dead_q;

  logic      sum_valid, sum_ready;
  sum_beat_t sum_beat;
  logic      pkt_valid, pkt_ready;
  pkt_beat_t pkt_beat;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= CENTER_RESET;
      dead_q   <= DEAD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_CENTER: center_q <= cfg_data_i[CENTER_W-1:0];
        REG_DEAD:   dead_q   <= cfg_data_i[DEAD_W-1:0];
        default:    ;
      endcase
    end
  end

  jac_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .axis_i      (axis_i),
    .sample_i    (sample_i),
    .sum_valid_o (sum_valid),
    .sum_ready_i (sum_ready),
    .sum_beat_o  (sum_beat)
  );

  jac_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sum_valid_i (sum_valid),
    .sum_ready_o (sum_ready),
    .sum_beat_i  (sum_beat),
    .center_i    (center_q),
    .dead_i      (dead_q),
    .pkt_valid_o (pkt_valid),
    .pkt_ready_i (pkt_ready),
    .pkt_beat_o  (pkt_beat)
  );

  jac_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pkt_valid_i   (pkt_valid),
    .pkt_ready_o   (pkt_ready),
    .pkt_beat_i    (pkt_beat),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .packet_byte_o (packet_byte_o),
    .last_byte_o   (last_byte_o)
  );

  // A packet, once started, continues without gaps
  `JAC_ASSERT_NEXT(a_pkt_no_gap, clk_i, rst_ni, out_valid_o && out_ready_i && !last_byte_o, out_valid_o, "packet broken mid-stream")

  // Input backpressure only comes from a full window stage
  `JAC_ASSERT(a_ready_cause, clk_i, rst_ni, !in_ready_o |-> (sum_valid && !sum_ready), "input stalled without a held beat")

  // A stalled scale-stage beat keeps its value
  `JAC_ASSERT_NEXT(a_pkt_hold, clk_i, rst_ni, pkt_valid && !pkt_ready, pkt_valid && $stable(pkt_beat), "stalled packet beat changed")

  // The axis byte that opens a burst after idle names an axis that exists
  `JAC_ASSERT(a_axis_byte, clk_i, rst_ni, (out_valid_o && $rose(out_valid_o)) |-> (32'(packet_byte_o) < AXIS_COUNT), "first byte is not an axis")

endmodule
